[hdl/tvps_pkg.sv]
package tvps_pkg;

    localparam int VALVE_W      = 4;
    localparam int TIME_IN_W    = 32;
    localparam int PULSE_W      = 16;
    localparam int ACTIVE_W     = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int NUM_VALVES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [PULSE_W-1:0]  PULSE_RESET  = PULSE_W'(20);
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);

    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LENGTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_VALVES = CFG_INDEX_W'(1);

    localparam logic MODE_SCHEDULE = 1'b0;
    localparam logic MODE_TICK     = 1'b1;

endpackage

[hdl/tvps_if.sv]
interface tvps_in_if;
    import tvps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [VALVE_W-1:0]   valve;
    logic [TIME_IN_W-1:0] start_time;
    logic [TIME_IN_W-1:0] current_time;

    modport source (output valid, mode, valve, start_time, current_time, input ready);
    modport sink   (input valid, mode, valve, start_time, current_time, output ready);
endinterface

interface tvps_out_if;
    import tvps_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALVE_W-1:0] valve_index;
    logic               valve_open;
    logic               event_dropped;
    logic               last;

    modport source (output valid, valve_index, valve_open, event_dropped, last, input ready);
    modport sink   (input valid, valve_index, valve_open, event_dropped, last, output ready);
endinterface

[hdl/tvps_ram.sv]
module tvps_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/timed_valve_pulse_scheduler.sv]
// Channel   Role    Handshake      Payload
// item      sink    valid/ready    mode, valve, start_time, current_time
// result    source  valid/ready    valve_index, valve_open, event_dropped, last
// cfg       write   cfg_we         cfg_index, cfg_data (no read-back)
//
// Schedule item: after the transfer, S_OPEN writes the open entry and S_CLOSE the close entry; a
// refused item goes from the room check in S_OPEN to S_DROP, which hands over the drop.
// Tick item: S_SCAN steps past each active valve with an empty queue; for a valve with entries
// it reads the entry RAM, then S_CMP compares in the shared adder. S_SCAN then finds the scan
// done, and S_FLUSH hands over the final result when anything was due.
// Reset clears pointers and fill counts at once; the entry RAM needs no clearing pass.
// A stalled result holds the sequencer only when a new result must be handed over.
module timed_valve_pulse_scheduler #(
    parameter int NUM_VALVES  = tvps_pkg::NUM_VALVES_DEF,
    parameter int QUEUE_DEPTH = tvps_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = tvps_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tvps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tvps_pkg::CFG_DATA_W-1:0]  cfg_data,
    tvps_in_if.sink                          item,
    tvps_out_if.source                       result
);
    import tvps_pkg::*;

    localparam int VW    = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;
    localparam int VCW   = $clog2(NUM_VALVES + 1);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int EW    = TIME_BITS + 1;
    localparam int AW    = VW + PW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OPEN  = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_DROP  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [VALVE_W-1:0]   valve_reg;
    logic [TIME_IN_W-1:0] start_reg;
    logic [TIME_IN_W-1:0] now_reg;
    logic [PULSE_W-1:0]   pulse_reg, pulse_next;
    logic [ACTIVE_W-1:0]  active_reg, active_next;
    logic [PW-1:0]        rp_reg [NUM_VALVES];
    logic [PW-1:0]        rp_next [NUM_VALVES];
    logic [PW-1:0]        wp_reg [NUM_VALVES];
    logic [PW-1:0]        wp_next [NUM_VALVES];
    logic [FW-1:0]        fill_reg [NUM_VALVES];
    logic [FW-1:0]        fill_next [NUM_VALVES];
    logic [VCW-1:0]       v_reg, v_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [VALVE_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                 pend_open_reg, pend_open_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALVE_W-1:0]   out_idx_reg, out_idx_next;
    logic                 out_open_reg, out_open_next;
    logic                 out_drop_reg, out_drop_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 out_free;
    logic [VW-1:0]        sv;
    logic [VW-1:0]        vi;
    logic                 valve_ok;
    logic                 no_room;
    logic [VCW-1:0]       limit;
    logic [TIME_BITS-1:0] alu_a, alu_b, alu_y;
    logic                 alu_sub;
    logic                 due;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, ram_rdata;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
        return r;
    endfunction

    tvps_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item.ready           = (state_reg == S_IDLE);
    assign accept               = item.valid && item.ready;
    assign out_free             = !out_valid_reg || result.ready;
    assign result.valid         = out_valid_reg;
    assign result.valve_index   = out_idx_reg;
    assign result.valve_open    = out_open_reg;
    assign result.event_dropped = out_drop_reg;
    assign result.last          = out_last_reg;

    assign sv       = VW'(valve_reg - VALVE_W'(1));
    assign vi       = v_reg[VW-1:0];
    assign valve_ok = (valve_reg != '0) && (int'(valve_reg) <= NUM_VALVES);
    assign no_room  = ({1'b0, fill_reg[sv]} + (FW+1)'(2)) > (FW+1)'(QUEUE_DEPTH);
    assign limit    = (int'(active_reg) > NUM_VALVES) ? VCW'(NUM_VALVES) : VCW'(active_reg);

    always_comb
    begin
        alu_sub = (state_reg == S_CMP);
        if (alu_sub)
        begin
            alu_a = TIME_BITS'(now_reg);
            alu_b = ram_rdata[EW-1:1];
        end
        else
        begin
            alu_a = TIME_BITS'(start_reg);
            alu_b = TIME_BITS'(pulse_reg);
        end
        alu_y = alu_a + (alu_b ^ {TIME_BITS{alu_sub}}) + TIME_BITS'(alu_sub);
    end

    assign due = !alu_y[TIME_BITS-1];

    always_comb
    begin
        state_next      = state_reg;
        pulse_next      = pulse_reg;
        active_next     = active_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        v_next          = v_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_open_next  = pend_open_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_idx_next    = out_idx_reg;
        out_open_next   = out_open_reg;
        out_drop_next   = out_drop_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = {sv, wp_reg[sv]};
        ram_wdata       = {TIME_BITS'(start_reg), 1'b1};
        ram_re          = 1'b0;
        ram_raddr       = {vi, rp_reg[vi]};

        if (cfg_we && cfg_index == CFG_PULSE_LENGTH)
        begin
            pulse_next = cfg_data[PULSE_W-1:0];
        end
        if (cfg_we && cfg_index == CFG_ACTIVE_VALVES)
        begin
            active_next = cfg_data[ACTIVE_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    v_next     = '0;
                    state_next = (item.mode == MODE_TICK) ? S_SCAN : S_OPEN;
                end
            end
            S_OPEN:
            begin
                if (!valve_ok || no_room)
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    ram_we      = 1'b1;
                    wp_next[sv] = ptr_inc(wp_reg[sv]);
                    state_next  = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                ram_we        = 1'b1;
                ram_wdata     = {alu_y, 1'b0};
                wp_next[sv]   = ptr_inc(wp_reg[sv]);
                fill_next[sv] = fill_reg[sv] + FW'(2);
                state_next    = S_IDLE;
            end
            S_DROP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = valve_reg;
                    out_open_next  = 1'b0;
                    out_drop_next  = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (v_reg == limit)
                begin
                    state_next = pend_valid_reg ? S_FLUSH : S_IDLE;
                end
                else if (fill_reg[vi] == '0)
                begin
                    v_next = v_reg + VCW'(1);
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!due)
                begin
                    v_next     = v_reg + VCW'(1);
                    state_next = S_SCAN;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = pend_idx_reg;
                        out_open_next  = pend_open_reg;
                        out_drop_next  = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = VALVE_W'(v_reg + VCW'(1));
                    pend_open_next  = ram_rdata[0];
                    rp_next[vi]     = ptr_inc(rp_reg[vi]);
                    fill_next[vi]   = fill_reg[vi] - FW'(1);
                    v_next          = v_reg + VCW'(1);
                    state_next      = S_SCAN;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = pend_idx_reg;
                    out_open_next   = pend_open_reg;
                    out_drop_next   = 1'b0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pulse_reg      <= PULSE_RESET;
            active_reg     <= ACTIVE_RESET;
            v_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_VALVES; i++)
            begin
                rp_reg[i]   <= '0;
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pulse_reg      <= pulse_next;
            active_reg     <= active_next;
            v_reg          <= v_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            valve_reg <= item.valve;
            start_reg <= item.start_time;
            now_reg   <= item.current_time;
        end
        pend_idx_reg  <= pend_idx_next;
        pend_open_reg <= pend_open_next;
        out_idx_reg   <= out_idx_next;
        out_open_reg  <= out_open_next;
        out_drop_reg  <= out_drop_next;
        out_last_reg  <= out_last_next;
    end

endmodule

[hdl/tvps_checker.sv]
module tvps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [tvps_pkg::VALVE_W-1:0] result_valve_index,
    input logic                         result_valve_open,
    input logic                         result_event_dropped,
    input logic                         result_last
);
    import tvps_pkg::*;

    logic [VALVE_W+2:0] payload;

    assign payload = {result_valve_index, result_valve_open, result_event_dropped, result_last};

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(payload))
        else $error("stalled result changed");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous item still in work");

    a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_event_dropped |-> result_last && !result_valve_open)
        else $error("drop result not marked final or marked open");

    a_change_has_valve: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_event_dropped |-> result_valve_index != '0)
        else $error("level change without a valve number");

endmodule

bind timed_valve_pulse_scheduler tvps_checker u_tvps_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .item_valid           (item.valid),
    .item_ready           (item.ready),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .result_valve_index   (result.valve_index),
    .result_valve_open    (result.valve_open),
    .result_event_dropped (result.event_dropped),
    .result_last          (result.last)
);

[tb/sv/tb_top.sv]
module tb_top;
    import tvps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_V           = NUM_VALVES_DEF;
    localparam int DEPTH           = QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES   = 40;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int PRINT_CAP       = 100;

    typedef struct packed {
        logic                 mode;
        logic [VALVE_W-1:0]   valve;
        logic [TIME_IN_W-1:0] start_time;
        logic [TIME_IN_W-1:0] current_time;
    } item_t;

    typedef struct packed {
        logic [VALVE_W-1:0] valve_index;
        logic               valve_open;
        logic               event_dropped;
        logic               last;
    } change_t;

    typedef struct packed {
        item_t   stim;
        logic    typed;
        logic    typed_one;
        change_t typed_change;
    } directed_row_t;

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse;
        logic [ACTIVE_W-1:0]  active;
        logic                 quiet;
        logic                 hold;
        logic                 pause;
        logic                 jump;
        logic [TIME_IN_W-1:0] jump_to;
    } phase_t;

    localparam change_t NO_CHANGE = '0;

    localparam directed_row_t DIRECTED_ROWS [22] = '{
        '{'{MODE_TICK,     4'd0,  32'd0,          32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd0,  32'd0,          32'hFFFF_FFFF},  1'b1, 1'b1,
          '{4'd0,  1'b0, 1'b1, 1'b1}},
        '{'{MODE_SCHEDULE, 4'd9,  32'hFFFF_FFFF,  32'd0},          1'b1, 1'b1,
          '{4'd9,  1'b0, 1'b1, 1'b1}},
        '{'{MODE_SCHEDULE, 4'd15, 32'h1234_5678,  32'hA5A5_A5A5},  1'b1, 1'b1,
          '{4'd15, 1'b0, 1'b1, 1'b1}},
        '{'{MODE_SCHEDULE, 4'd1,  32'd100,        32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd8,  32'hFFFF_FFF0,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd4,  32'd0,          32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_TICK,     4'd15, 32'hFFFF_FFFF,  32'd99},         1'b0, 1'b0, NO_CHANGE},
        '{'{MODE_TICK,     4'd0,  32'd0,          32'd100},        1'b0, 1'b0, NO_CHANGE},
        '{'{MODE_TICK,     4'd7,  32'h5A5A_5A5A,  32'h8000_0064},  1'b0, 1'b0, NO_CHANGE},
        '{'{MODE_TICK,     4'd0,  32'd0,          32'hFFFF_FFFF},  1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b0, NO_CHANGE},
        '{'{MODE_SCHEDULE, 4'd2,  32'h7FFF_FFFF,  32'd0},          1'b1, 1'b1,
          '{4'd2,  1'b0, 1'b1, 1'b1}},
        '{'{MODE_TICK,     4'd2,  32'd0,          32'h7FFF_FFFF},  1'b0, 1'b0, NO_CHANGE},
        '{'{MODE_TICK,     4'd2,  32'd0,          32'h7FFF_FFFF},  1'b0, 1'b0, NO_CHANGE}
    };

    localparam phase_t PHASE_PLAN [8] = '{
        '{16'd0,     4'd8,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{16'd65535, 4'd1,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{16'd5,     4'd0,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{16'd37,    4'd15, 1'b1, 1'b0, 1'b0, 1'b1, 32'h7FFF_0000},
        '{16'd20,    4'd9,  1'b0, 1'b1, 1'b0, 1'b0, 32'd0},
        '{16'd1,     4'd4,  1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{16'd300,   4'd8,  1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FF00},
        '{16'd20,    4'd8,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tvps_in_if  item_bus ();
    tvps_out_if result_bus ();

    timed_valve_pulse_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    always #10 clk = ~clk;

    logic [TIME_IN_W-1:0] slot_when [NUM_V][DEPTH];
    logic                 slot_open [NUM_V][DEPTH];
    int unsigned          rd_ptr [NUM_V];
    int unsigned          wr_ptr [NUM_V];
    int unsigned          fill   [NUM_V];
    logic [PULSE_W-1:0]   pulse_len  = PULSE_RESET;
    logic [ACTIVE_W-1:0]  active_cnt = ACTIVE_RESET;

    change_t              awaited_changes [$];
    logic [TIME_IN_W-1:0] clock_ms = '0;
    bit                   quiet_mode = 1'b0;
    int                   hold_requests = 0;
    int                   mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("tb_top: mismatch on %s: got %0h, want %0h at %0t",
                     what, got, want, $time);
    endtask

    function automatic int idle_cycles();
        int pick;
        if (quiet_mode)
            return 0;
        pick = int'($urandom_range(0, 99));
        if (pick < 60)
            return 0;
        if (pick < 93)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    task automatic queue_entry(input int v, input logic [TIME_IN_W-1:0] when,
                               input logic open);
        slot_when[v][wr_ptr[v]] = when;
        slot_open[v][wr_ptr[v]] = open;
        wr_ptr[v] = (wr_ptr[v] + 1) % DEPTH;
        fill[v]++;
    endtask

    task automatic advance_valves(input item_t it);
        int                   v;
        int                   lim;
        logic [TIME_IN_W-1:0] diff;
        logic [TIME_IN_W-1:0] close_at;
        change_t              held;
        bit                   have;
        have = 1'b0;
        if (it.mode == MODE_SCHEDULE)
        begin
            v = int'(it.valve) - 1;
            if (it.valve == 0 || it.valve > NUM_V)
                awaited_changes.push_back('{it.valve, 1'b0, 1'b1, 1'b1});
            else if (fill[v] + 2 > DEPTH)
                awaited_changes.push_back('{it.valve, 1'b0, 1'b1, 1'b1});
            else
            begin
                close_at = it.start_time + TIME_IN_W'(pulse_len);
                queue_entry(v, it.start_time, 1'b1);
                queue_entry(v, close_at, 1'b0);
            end
            return;
        end
        lim = (active_cnt > NUM_V) ? NUM_V : int'(active_cnt);
        for (v = 0; v < lim; v++)
        begin
            if (fill[v] == 0)
                continue;
            diff = it.current_time - slot_when[v][rd_ptr[v]];
            if (diff[TIME_IN_W-1])
                continue;
            if (have)
                awaited_changes.push_back(held);
            held = '{VALVE_W'(v + 1), slot_open[v][rd_ptr[v]], 1'b0, 1'b0};
            have = 1'b1;
            rd_ptr[v] = (rd_ptr[v] + 1) % DEPTH;
            fill[v]--;
        end
        if (have)
        begin
            held.last = 1'b1;
            awaited_changes.push_back(held);
        end
    endtask

    function automatic item_t random_item();
        item_t it;
        it.valve        = VALVE_W'($urandom_range(0, 15));
        it.start_time   = $urandom;
        it.current_time = $urandom;
        if ($urandom_range(0, 99) < 45)
        begin
            it.mode = MODE_SCHEDULE;
            if ($urandom_range(0, 19) != 0)
                it.valve = VALVE_W'($urandom_range(1, NUM_V));
            if ($urandom_range(0, 24) != 0)
                it.start_time = clock_ms + TIME_IN_W'($urandom_range(0, 80)) - 32'd20;
        end
        else
        begin
            it.mode = MODE_TICK;
            if ($urandom_range(0, 99) < 97)
            begin
                clock_ms = clock_ms + TIME_IN_W'($urandom_range(0, 25));
                it.current_time = clock_ms;
            end
        end
        return it;
    endfunction

    task automatic offer(input item_t it);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.mode         <= it.mode;
        item_bus.valve        <= it.valve;
        item_bus.start_time   <= it.start_time;
        item_bus.current_time <= it.current_time;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
    endtask

    task automatic drain(input int extra);
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (awaited_changes.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic load_settings(input logic [PULSE_W-1:0] pulse,
                                 input logic [ACTIVE_W-1:0] active);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PULSE_LENGTH;
        cfg_data  <= CFG_DATA_W'(pulse);
        @(posedge clk);
        cfg_index <= CFG_ACTIVE_VALVES;
        cfg_data  <= CFG_DATA_W'(active);
        @(posedge clk);
        cfg_we     <= 1'b0;
        pulse_len  = pulse;
        active_cnt = active;
    endtask

    task automatic check_change();
        change_t got;
        change_t want;
        got = '{result_bus.valve_index, result_bus.valve_open,
                result_bus.event_dropped, result_bus.last};
        if (awaited_changes.size() == 0)
        begin
            report_mismatch("unexpected transfer", 32'(got), 32'hFFFF_FFFF);
            return;
        end
        want = awaited_changes.pop_front();
        if (got.valve_index !== want.valve_index)
            report_mismatch("valve_index", 32'(got.valve_index), 32'(want.valve_index));
        if (got.valve_open !== want.valve_open)
            report_mismatch("valve_open", 32'(got.valve_open), 32'(want.valve_open));
        if (got.event_dropped !== want.event_dropped)
            report_mismatch("event_dropped", 32'(got.event_dropped), 32'(want.event_dropped));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    initial
    begin : result_sink
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
                check_change();
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                stall_left = idle_cycles();
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        directed_row_t row;
        item_t         it;
        int            queued_prior;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        item_bus.valid        = 1'b0;
        item_bus.mode         = MODE_SCHEDULE;
        item_bus.valve        = '0;
        item_bus.start_time   = '0;
        item_bus.current_time = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            offer(row.stim);
            queued_prior = awaited_changes.size();
            advance_valves(row.stim);
            if (row.typed)
            begin
                while (awaited_changes.size() > queued_prior)
                    void'(awaited_changes.pop_back());
                if (row.typed_one)
                    awaited_changes.push_back(row.typed_change);
            end
        end

        foreach (PHASE_PLAN[p])
        begin
            drain(SETTLE_CYCLES);
            load_settings(PHASE_PLAN[p].pulse, PHASE_PLAN[p].active);
            quiet_mode = PHASE_PLAN[p].quiet;
            if (PHASE_PLAN[p].jump)
                clock_ms = PHASE_PLAN[p].jump_to;
            // hold off the result side while items keep coming
            if (PHASE_PLAN[p].hold)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (PHASE_PLAN[p].pause && n == ITEMS_PER_PHASE / 2)
                    drain(0);
                it = random_item();
                offer(it);
                advance_valves(it);
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
